[rtl/pet_pkg.sv]
// shared types, constants and tables for the polyline extrusion block
`timescale 1ns / 1ps

package pet_pkg;

  localparam int CW  = 20;        // point coordinate width
  localparam int FB  = 8;         // fraction bits of vertex positions
  localparam int VW  = 29;        // vertex position width
  localparam int HW  = 12;        // half width register
  localparam int TW  = 16;        // texture and index width
  localparam int UW  = 30;        // normalized magnitude width
  localparam int SQW = 62;        // sum of squares and root work width
  localparam int LW  = 31;        // segment length width
  localparam int QW  = 21;        // offset magnitude width
  localparam int DW  = 52;        // division remainder width
  localparam int OW  = QW + 2;    // signed offset sum width
  localparam int PW  = VW + 1;    // unsaturated position width
  localparam int JOB_DEPTH = 2;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [2:0] REG_HALF_WIDTH = 3'd0;
  localparam logic [2:0] REG_TEX_MIN_U  = 3'd1;
  localparam logic [2:0] REG_TEX_MIN_V  = 3'd2;
  localparam logic [2:0] REG_TEX_MAX_U  = 3'd3;
  localparam logic [2:0] REG_TEX_MAX_V  = 3'd4;
  localparam logic [2:0] REG_FIRST_VI   = 3'd5;

  typedef struct packed {
    logic [HW-1:0] half_width;
    logic [TW-1:0] tex_min_u;
    logic [TW-1:0] tex_min_v;
    logic [TW-1:0] tex_max_u;
    logic [TW-1:0] tex_max_v;
    logic [TW-1:0] first_vi;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic                 lone;
    logic                 last;
    logic                 neg_x;
    logic                 neg_y;
    logic [QW-1:0]        qx;
    logic [QW-1:0]        qy;
    logic [TW-1:0]        base;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_NORM, F_SQ1, F_SQ2, F_SQRT, F_MULX, F_MULY, F_DIV
  } fstate_t;

  typedef enum logic [2:0] {
    OFF_S, OFF_N, OFF_SW, OFF_NW, OFF_SE, OFF_NE
  } off_t;

  typedef struct packed {
    logic use_b;
    off_t off;
    logic u_min;
    logic v_max;
  } vsel_t;

  function automatic vsel_t vertex_sel(input logic [3:0] idx);
    vsel_t s;
    s.use_b = 1'b1;
    s.off   = OFF_S;
    s.u_min = 1'b0;
    s.v_max = idx[0];
    case (idx)
      4'd0: begin s.use_b = 1'b0; s.off = OFF_SW; s.u_min = 1'b1; end
      4'd1: begin s.use_b = 1'b0; s.off = OFF_NW; s.u_min = 1'b1; end
      4'd2: begin s.use_b = 1'b0; s.off = OFF_S; end
      4'd3: begin s.use_b = 1'b0; s.off = OFF_N; end
      4'd4, 4'd6: s.off = OFF_S;
      4'd5, 4'd7: s.off = OFF_N;
      4'd8: begin s.off = OFF_SE; s.u_min = 1'b1; end
      4'd9: begin s.off = OFF_NE; s.u_min = 1'b1; end
      default: s.off = OFF_S;
    endcase
    return s;
  endfunction

  // corner offsets from the segment's vertex base, a b c packed low to high
  function automatic logic [11:0] tri_corners(input logic [2:0] t);
    logic [11:0] c;
    case (t)
      3'd0: c = {4'd2, 4'd1, 4'd0};
      3'd1: c = {4'd3, 4'd1, 4'd2};
      3'd2: c = {4'd4, 4'd3, 4'd2};
      3'd3: c = {4'd5, 4'd3, 4'd4};
      3'd4: c = {4'd8, 4'd7, 4'd6};
      3'd5: c = {4'd9, 4'd7, 4'd8};
      default: c = 12'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/pet_if.sv]
// point and result channel interfaces
`timescale 1ns / 1ps

interface pet_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [pet_pkg::CW-1:0] point_x;
  logic signed [pet_pkg::CW-1:0] point_y;
  logic                        last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface pet_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    result_kind;
  logic signed [pet_pkg::VW-1:0] vertex_x;
  logic signed [pet_pkg::VW-1:0] vertex_y;
  logic [pet_pkg::TW-1:0]        tex_u;
  logic [pet_pkg::TW-1:0]        tex_v;
  logic [pet_pkg::TW-1:0]        corner_a;
  logic [pet_pkg::TW-1:0]        corner_b;
  logic [pet_pkg::TW-1:0]        corner_c;
  logic                          run_end;
  modport source (output valid, result_kind, vertex_x, vertex_y, tex_u, tex_v,
                  corner_a, corner_b, corner_c, run_end, input ready);
  modport sink   (input valid, result_kind, vertex_x, vertex_y, tex_u, tex_v,
                  corner_a, corner_b, corner_c, run_end, output ready);
endinterface

[rtl/pet_front.sv]
// point intake and segment offset computation (normalize, root, divide)
`timescale 1ns / 1ps

module pet_front (
  input  logic          clk,
  input  logic          rst_n,
  input  pet_pkg::cfg_t cfg,
  pet_in_if.sink        in_pt,
  input  logic          q_full,
  output logic          q_push,
  output pet_pkg::job_t q_job
);
  import pet_pkg::*;

  fstate_t state_r, state_nxt;
  logic    push_pend_r;

  logic signed [CW-1:0] px_r, py_r;
  logic                 have_prev_r;
  logic [TW-1:0]        base_r;
  job_t                 job_r;

  logic [UW-1:0]  ux_r, uy_r;
  logic [SQW-1:0] rem_r, root_r, bit_r;
  logic [4:0]     cnt_r;
  logic [DW-1:0]  remx_r, remy_r, dv_r;
  logic [QW-1:0]  qx_r, qy_r;

  logic                 acc;
  logic signed [CW:0]   dx, dy;
  logic [CW:0]          adx, ady;
  logic                 seg_zero;
  logic [UW-1:0]        m;
  logic [LW-1:0]        len;
  logic [HW+FB-1:0]     sc;
  logic [49:0]          prod;
  logic [SQW-1:0]       sq_term, root_try;

  assign acc = in_pt.valid && in_pt.ready;
  assign dx  = (CW+1)'(in_pt.point_x) - (CW+1)'(px_r);
  assign dy  = (CW+1)'(in_pt.point_y) - (CW+1)'(py_r);
  assign adx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
  assign ady = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
  assign seg_zero = (adx == '0) && (ady == '0);
  assign m   = (ux_r > uy_r) ? ux_r : uy_r;
  assign len = root_r[LW-1:0];
  assign sc  = {cfg.half_width, {FB{1'b0}}};
  assign prod = (state_r == F_MULX) ? 50'(ux_r) * 50'(sc) : 50'(uy_r) * 50'(sc);
  assign sq_term = (state_r == F_SQ1) ? SQW'(ux_r) * SQW'(ux_r)
                                      : SQW'(uy_r) * SQW'(uy_r);
  assign root_try = root_r + bit_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (acc && have_prev_r && !seg_zero) state_nxt = F_NORM;
      end
      F_NORM: if (m[UW-1]) state_nxt = F_SQ1;
      F_SQ1:  state_nxt = F_SQ2;
      F_SQ2:  state_nxt = F_SQRT;
      F_SQRT: if (cnt_r == '0) state_nxt = F_MULX;
      F_MULX: state_nxt = F_MULY;
      F_MULY: state_nxt = F_DIV;
      F_DIV:  if (cnt_r == '0) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_pt.ready = (state_r == F_IDLE) && !push_pend_r;
    q_push      = push_pend_r && !q_full;
    q_job       = job_r;
    q_job.qx    = qx_r;
    q_job.qy    = qy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      push_pend_r <= 1'b0;
      have_prev_r <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
      base_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_push) push_pend_r <= 1'b0;
      if (state_r == F_DIV && cnt_r == '0) push_pend_r <= 1'b1;
      if (acc) begin
        if (!have_prev_r) begin
          if (in_pt.last_point) begin
            push_pend_r <= 1'b1;
          end else begin
            px_r        <= in_pt.point_x;
            py_r        <= in_pt.point_y;
            have_prev_r <= 1'b1;
            base_r      <= cfg.first_vi;
          end
        end else begin
          if (seg_zero) push_pend_r <= 1'b1;
          if (in_pt.last_point) begin
            have_prev_r <= 1'b0;
          end else begin
            px_r   <= in_pt.point_x;
            py_r   <= in_pt.point_y;
            base_r <= base_r + TW'(6);
          end
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (acc) begin
          job_r.ax    <= px_r;
          job_r.ay    <= py_r;
          job_r.bx    <= in_pt.point_x;
          job_r.by    <= in_pt.point_y;
          job_r.lone  <= !have_prev_r;
          job_r.last  <= in_pt.last_point;
          job_r.neg_x <= dx[CW];
          job_r.neg_y <= dy[CW];
          job_r.qx    <= '0;
          job_r.qy    <= '0;
          job_r.base  <= base_r;
          qx_r        <= '0;
          qy_r        <= '0;
          ux_r        <= UW'(adx);
          uy_r        <= UW'(ady);
        end
      end
      F_NORM: begin
        if (!m[UW-1]) begin
          // coarse step while far below the target octave
          if (m[UW-1:UW-8] == '0) begin
            ux_r <= ux_r << 8;
            uy_r <= uy_r << 8;
          end else begin
            ux_r <= ux_r << 1;
            uy_r <= uy_r << 1;
          end
        end
      end
      F_SQ1: rem_r <= sq_term;
      F_SQ2: begin
        rem_r  <= rem_r + sq_term;
        root_r <= '0;
        bit_r  <= SQW'(1) << 60;
        cnt_r  <= 5'd30;
      end
      F_SQRT: begin
        if (rem_r >= root_try) begin
          rem_r  <= rem_r - root_try;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 5'd1;
      end
      F_MULX: remx_r <= DW'(prod) + DW'(len >> 1);
      F_MULY: begin
        remy_r <= DW'(prod) + DW'(len >> 1);
        dv_r   <= DW'(len) << (QW - 1);
        cnt_r  <= 5'(QW - 1);
      end
      F_DIV: begin
        if (remx_r >= dv_r) begin
          remx_r <= remx_r - dv_r;
          qx_r   <= {qx_r[QW-2:0], 1'b1};
        end else begin
          qx_r <= {qx_r[QW-2:0], 1'b0};
        end
        if (remy_r >= dv_r) begin
          remy_r <= remy_r - dv_r;
          qy_r   <= {qy_r[QW-2:0], 1'b1};
        end else begin
          qy_r <= {qy_r[QW-2:0], 1'b0};
        end
        dv_r  <= dv_r >> 1;
        cnt_r <= cnt_r - 5'd1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/pet_queue.sv]
// two-entry job queue between front and back
`timescale 1ns / 1ps

module pet_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pet_pkg::job_t push_job,
  input  logic          pop,
  output pet_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import pet_pkg::*;

  job_t       mem [JOB_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'(JOB_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("job popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(JOB_DEPTH))
    else $error("queue count out of range");

endmodule

[rtl/pet_back.sv]
// result sequencer: vertices and triangles of one segment, one beat a cycle while the receiver is ready
`timescale 1ns / 1ps

module pet_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pet_pkg::cfg_t cfg,
  input  pet_pkg::job_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  pet_out_if.source     out_res
);
  import pet_pkg::*;

  job_t       job_r;
  logic       busy_r;
  logic [3:0] step_r;
  logic       out_valid_r;

  logic [1:0]            kind_r;
  logic signed [VW-1:0]  vx_r, vy_r;
  logic [TW-1:0]         tu_r, tv_r, ca_r, cb_r, cc_r;
  logic                  end_r;

  logic                  fire;
  logic [3:0]            total, nverts;
  logic                  is_vert;
  vsel_t                 vs;
  logic [11:0]           tc;
  logic [3:0]            tidx;
  logic signed [QW:0]    ex, ey;
  logic signed [OW-1:0]  ox, oy;
  logic signed [CW-1:0]  ptx, pty;
  logic signed [PW-1:0]  posx, posy;
  logic [TW-1:0]         mid_u;
  logic [TW:0]           mid_sum;

  function automatic logic signed [VW-1:0] sat(input logic signed [PW-1:0] p);
    if (p[PW-1] != p[PW-2]) return p[PW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    return p[VW-1:0];
  endfunction

  assign q_pop = !busy_r && !q_empty;
  assign fire  = busy_r && (!out_valid_r || out_res.ready);
  assign nverts = job_r.last ? 4'd10 : 4'd6;
  assign total  = job_r.lone ? 4'd0 : (job_r.last ? 4'd15 : 4'd9);  // last step number
  assign is_vert = step_r < nverts;
  assign tidx   = step_r - nverts;
  assign vs     = vertex_sel(step_r);
  assign tc     = tri_corners(tidx[2:0]);

  assign ex = job_r.neg_x ? -$signed({1'b0, job_r.qx}) : $signed({1'b0, job_r.qx});
  assign ey = job_r.neg_y ? -$signed({1'b0, job_r.qy}) : $signed({1'b0, job_r.qy});

  always_comb begin
    case (vs.off)
      OFF_S:   begin ox = OW'(ey);      oy = -OW'(ex);      end
      OFF_N:   begin ox = -OW'(ey);     oy = OW'(ex);       end
      OFF_SW:  begin ox = OW'(ey) - OW'(ex);  oy = -OW'(ey) - OW'(ex); end
      OFF_NW:  begin ox = -OW'(ey) - OW'(ex); oy = OW'(ex) - OW'(ey);  end
      OFF_SE:  begin ox = OW'(ey) + OW'(ex);  oy = OW'(ey) - OW'(ex);  end
      OFF_NE:  begin ox = OW'(ex) - OW'(ey);  oy = OW'(ey) + OW'(ex);  end
      default: begin ox = '0; oy = '0; end
    endcase
  end

  assign ptx  = vs.use_b ? job_r.bx : job_r.ax;
  assign pty  = vs.use_b ? job_r.by : job_r.ay;
  assign posx = ($signed(PW'(ptx)) <<< FB) + PW'(ox);
  assign posy = ($signed(PW'(pty)) <<< FB) + PW'(oy);
  assign mid_sum = {1'b0, cfg.tex_min_u} + {1'b0, cfg.tex_max_u};
  assign mid_u   = mid_sum[TW:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        if (step_r == total) busy_r <= 1'b0;
        else step_r <= step_r + 4'd1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_head;
    if (fire) begin
      end_r <= (step_r == total);
      kind_r <= KIND_VERTEX;
      vx_r <= '0; vy_r <= '0; tu_r <= '0; tv_r <= '0;
      ca_r <= '0; cb_r <= '0; cc_r <= '0;
      if (job_r.lone) begin
        kind_r <= KIND_ERROR;
      end else if (is_vert) begin
        vx_r <= sat(posx);
        vy_r <= sat(posy);
        tu_r <= vs.u_min ? cfg.tex_min_u : mid_u;
        tv_r <= vs.v_max ? cfg.tex_max_v : cfg.tex_min_v;
      end else begin
        kind_r <= KIND_TRIANGLE;
        ca_r <= job_r.base + TW'(tc[3:0]);
        cb_r <= job_r.base + TW'(tc[7:4]);
        cc_r <= job_r.base + TW'(tc[11:8]);
      end
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.result_kind = kind_r;
  assign out_res.vertex_x    = vx_r;
  assign out_res.vertex_y    = vy_r;
  assign out_res.tex_u       = tu_r;
  assign out_res.tex_v       = tv_r;
  assign out_res.corner_a    = ca_r;
  assign out_res.corner_b    = cb_r;
  assign out_res.corner_c    = cc_r;
  assign out_res.run_end     = end_r;

  a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_ERROR |-> end_r)
    else $error("error beat without run end");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !fire)
    else $error("job loaded while a run is in progress");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= total)
    else $error("step past end of run");

endmodule

[rtl/polyline_extrude_to_triangles.sv]
// top level: configuration registers, front, job queue and back
`timescale 1ns / 1ps
// Polyline stroke extrusion. Points enter on in_pt (valid/ready), one beat per
// point; last_point closes the polyline. Each segment gives six vertices and
// four triangles on out_res, ten beats, sixteen when it is the last segment.
// A lone point gives a single error beat. run_end marks the final beat of a
// point. The first point of a polyline gives no beats.
// Registers are written through cfg_we / cfg_index / cfg_wdata, one per cycle;
// the user must write them only while the block is idle; the block does not enforce it.
// Flow: the front takes one point at a time; a segment's offset is computed there by
// the normalize shifter, the 31-step bit-pair square root and the 21-step
// restoring divider. A first point, a lone point or a zero-length segment skips
// them. A two-deep job queue lets the back emit one beat per cycle (10 or 16 per
// segment) while the receiver is ready and the front works on the next point.
// Reset (rst_n low, synchronous) clears the polyline state and restores the
// register defaults. When the receiver stalls, the output beat holds and the
// back stops; the front stops once the queue is full.
module polyline_extrude_to_triangles (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [pet_pkg::TW-1:0]       cfg_wdata,
  pet_in_if.sink                       in_pt,
  pet_out_if.source                    out_res
);
  import pet_pkg::*;

  cfg_t cfg_r;
  job_t push_job, head;
  logic push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_width <= HW'(1);
      cfg_r.tex_min_u  <= '0;
      cfg_r.tex_min_v  <= '0;
      cfg_r.tex_max_u  <= '1;
      cfg_r.tex_max_v  <= '1;
      cfg_r.first_vi   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_WIDTH: cfg_r.half_width <= cfg_wdata[HW-1:0];
        REG_TEX_MIN_U:  cfg_r.tex_min_u  <= cfg_wdata;
        REG_TEX_MIN_V:  cfg_r.tex_min_v  <= cfg_wdata;
        REG_TEX_MAX_U:  cfg_r.tex_max_u  <= cfg_wdata;
        REG_TEX_MAX_V:  cfg_r.tex_max_v  <= cfg_wdata;
        REG_FIRST_VI:   cfg_r.first_vi   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pet_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_pt,
    .q_full(full), .q_push(push), .q_job(push_job)
  );

  pet_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop, .head, .full, .empty
  );

  pet_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_head(head), .q_empty(empty), .q_pop(pop), .out_res
  );

endmodule

[verif/tb.sv]
// self-checking testbench for the polyline stroke extrusion block
`timescale 1ns / 1ps

module tb;
  import pet_pkg::*;

  localparam logic [2:0] REG_NONE_LO = 3'd6;  // indexes past the register file
  localparam logic [2:0] REG_NONE_HI = 3'd7;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } point_t;

  typedef struct {
    logic [1:0]           kind;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic [TW-1:0]        u;
    logic [TW-1:0]        v;
    logic [TW-1:0]        ca;
    logic [TW-1:0]        cb;
    logic [TW-1:0]        cc;
    logic                 run_end;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [TW-1:0] cfg_wdata = '0;

  pet_in_if  in_pt ();
  pet_out_if out_res ();

  polyline_extrude_to_triangles dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_pt(in_pt.sink), .out_res(out_res.source)
  );

  // predictor state
  logic [HW-1:0] m_half_width = 12'd1;
  logic [TW-1:0] m_min_u = '0, m_min_v = '0, m_max_u = 16'hFFFF, m_max_v = 16'hFFFF;
  logic [TW-1:0] m_first_vi = '0, m_vbase = '0;
  longint m_prev_x = 0, m_prev_y = 0;
  bit m_have_prev = 0;

  point_t pending_pts[$];
  beat_t  expected_beats[$];
  point_t cur_pt;
  int errors = 0;
  int beats_seen = 0;
  bit quiet = 0;
  int hold_left = 0;
  bit hold_done = 0;

  initial forever #4 clk = ~clk;

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned val);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > val) b >>= 2;
    while (b != 0) begin
      if (val >= r + b) begin
        val -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void push_vertex(input longint px, input longint py, input longint ox,
                                      input longint oy, input logic [TW-1:0] u,
                                      input logic [TW-1:0] v);
    beat_t b;
    longint x = px * (64'sd1 << FB) + ox;
    longint y = py * (64'sd1 << FB) + oy;
    if (x > 268435455) x = 268435455;
    if (x < -268435456) x = -268435456;
    if (y > 268435455) y = 268435455;
    if (y < -268435456) y = -268435456;
    b = '{KIND_VERTEX, x[VW-1:0], y[VW-1:0], u, v, '0, '0, '0, 1'b0};
    expected_beats.push_back(b);
  endfunction

  function automatic void push_triangle(input int a, input int b, input int c);
    beat_t t;
    t = '{KIND_TRIANGLE, '0, '0, '0, '0, TW'(m_vbase + a), TW'(m_vbase + b),
          TW'(m_vbase + c), 1'b0};
    expected_beats.push_back(t);
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [TW-1:0] val);
    case (idx)
      REG_HALF_WIDTH: m_half_width = val[HW-1:0];
      REG_TEX_MIN_U:  m_min_u = val;
      REG_TEX_MIN_V:  m_min_v = val;
      REG_TEX_MAX_U:  m_max_u = val;
      REG_TEX_MAX_V:  m_max_v = val;
      REG_FIRST_VI:   m_first_vi = val;
      default: ;
    endcase
  endfunction

  // expected beats for one accepted point
  function automatic void predict_stroke(input point_t p);
    longint bx = p.x, by = p.y, dx, dy, ex = 0, ey = 0;
    longint unsigned ux, uy, mag, len, sc;
    logic [TW-1:0] mid_u;
    beat_t e;
    if (!m_have_prev) begin
      if (p.last) begin
        e = '{KIND_ERROR, '0, '0, '0, '0, '0, '0, '0, 1'b1};
        expected_beats.push_back(e);
      end else begin
        m_prev_x = bx;
        m_prev_y = by;
        m_have_prev = 1;
        m_vbase = m_first_vi;
      end
      return;
    end
    dx = bx - m_prev_x;
    dy = by - m_prev_y;
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    mag = ux > uy ? ux : uy;
    if (mag != 0) begin
      sc = longint'(m_half_width) << FB;
      while (mag >= (64'd1 << 30)) begin ux >>= 1; uy >>= 1; mag >>= 1; end
      while (mag < (64'd1 << 29)) begin ux <<= 1; uy <<= 1; mag <<= 1; end
      len = int_sqrt(ux * ux + uy * uy);
      ex = (ux * sc + len / 2) / len;
      ey = (uy * sc + len / 2) / len;
      if (dx < 0) ex = -ex;
      if (dy < 0) ey = -ey;
    end
    mid_u = TW'(({1'b0, m_min_u} + {1'b0, m_max_u}) >> 1);
    push_vertex(m_prev_x, m_prev_y, ey - ex, -ey - ex, m_min_u, m_min_v);
    push_vertex(m_prev_x, m_prev_y, -ey - ex, ex - ey, m_min_u, m_max_v);
    push_vertex(m_prev_x, m_prev_y, ey, -ex, mid_u, m_min_v);
    push_vertex(m_prev_x, m_prev_y, -ey, ex, mid_u, m_max_v);
    push_vertex(bx, by, ey, -ex, mid_u, m_min_v);
    push_vertex(bx, by, -ey, ex, mid_u, m_max_v);
    if (p.last) begin
      push_vertex(bx, by, ey, -ex, mid_u, m_min_v);
      push_vertex(bx, by, -ey, ex, mid_u, m_max_v);
      push_vertex(bx, by, ey + ex, ey - ex, m_min_u, m_min_v);
      push_vertex(bx, by, ex - ey, ey + ex, m_min_u, m_max_v);
    end
    push_triangle(0, 1, 2);
    push_triangle(2, 1, 3);
    push_triangle(2, 3, 4);
    push_triangle(4, 3, 5);
    if (p.last) begin
      push_triangle(6, 7, 8);
      push_triangle(8, 7, 9);
      m_have_prev = 0;
    end else begin
      m_prev_x = bx;
      m_prev_y = by;
      m_vbase = m_vbase + 16'd6;
    end
    expected_beats[expected_beats.size() - 1].run_end = 1'b1;
  endfunction

  // point driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_pt.valid <= 1'b0;
      in_pt.point_x <= '0;
      in_pt.point_y <= '0;
      in_pt.last_point <= 1'b0;
    end else if (!in_pt.valid || in_pt.ready) begin
      if (in_pt.valid) predict_stroke(cur_pt);
      if (pending_pts.size() != 0 && (quiet || $urandom_range(99) >= 24)) begin
        cur_pt = pending_pts.pop_front();
        in_pt.valid <= 1'b1;
        in_pt.point_x <= cur_pt.x;
        in_pt.point_y <= cur_pt.y;
        in_pt.last_point <= cur_pt.last;
      end else begin
        in_pt.valid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off while points keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_seen >= 800) begin
      hold_done <= 1'b1;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    beat_t e;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          report("beat with nothing expected");
        end else begin
          e = expected_beats.pop_front();
          if (out_res.result_kind !== e.kind)
            report($sformatf("kind %0d exp %0d", out_res.result_kind, e.kind));
          if (out_res.vertex_x !== e.vx)
            report($sformatf("vertex_x %0d exp %0d", out_res.vertex_x, e.vx));
          if (out_res.vertex_y !== e.vy)
            report($sformatf("vertex_y %0d exp %0d", out_res.vertex_y, e.vy));
          if (out_res.tex_u !== e.u) report($sformatf("tex_u %h exp %h", out_res.tex_u, e.u));
          if (out_res.tex_v !== e.v) report($sformatf("tex_v %h exp %h", out_res.tex_v, e.v));
          if (out_res.corner_a !== e.ca)
            report($sformatf("corner_a %0d exp %0d", out_res.corner_a, e.ca));
          if (out_res.corner_b !== e.cb)
            report($sformatf("corner_b %0d exp %0d", out_res.corner_b, e.cb));
          if (out_res.corner_c !== e.cc)
            report($sformatf("corner_c %0d exp %0d", out_res.corner_c, e.cc));
          if (out_res.run_end !== e.run_end)
            report($sformatf("run_end %b exp %b", out_res.run_end, e.run_end));
        end
      end
      if (hold_left > 0) begin
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= quiet || $urandom_range(99) >= 24;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [TW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic write_all(input logic [HW-1:0] hw, input logic [TW-1:0] mnu,
                           input logic [TW-1:0] mnv, input logic [TW-1:0] mxu,
                           input logic [TW-1:0] mxv, input logic [TW-1:0] fvi);
    write_reg(REG_HALF_WIDTH, TW'(hw));
    write_reg(REG_TEX_MIN_U, mnu);
    write_reg(REG_TEX_MIN_V, mnv);
    write_reg(REG_TEX_MAX_U, mxu);
    write_reg(REG_TEX_MAX_V, mxv);
    write_reg(REG_FIRST_VI, fvi);
  endtask

  task automatic add_point(input longint x, input longint y, input bit last);
    point_t p;
    p.x = x[CW-1:0];
    p.y = y[CW-1:0];
    p.last = last;
    pending_pts.push_back(p);
  endtask

  function automatic longint rand_coord();
    int sel = $urandom_range(9);
    if (sel == 0) return $urandom_range(1) ? 524287 : -524288;
    if (sel < 4) return longint'($urandom_range(64)) - 32;
    return longint'($urandom_range(1048575)) - 524288;
  endfunction

  // a polyline of random content, mostly short hops with some long ones
  task automatic add_polyline(input int npts);
    longint x = rand_coord(), y = rand_coord();
    for (int i = 0; i < npts; i++) begin
      add_point(x, y, i == npts - 1);
      case ($urandom_range(5))
        0: ;  // repeated point
        1: begin x = rand_coord(); y = rand_coord(); end
        default: begin
          x = x + longint'($urandom_range(2000)) - 1000;
          y = y + longint'($urandom_range(2000)) - 1000;
        end
      endcase
      if (x > 524287) x = 524287;
      if (x < -524288) x = -524288;
      if (y > 524287) y = 524287;
      if (y < -524288) y = -524288;
    end
  endtask

  task automatic drain();
    while (pending_pts.size() != 0 || in_pt.valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, lone point, zero length, extremes, short polyline
    add_point(5, 5, 1);
    add_point(0, 0, 0);
    add_point(0, 0, 0);
    add_point(10, 0, 0);
    add_point(10, -7, 1);
    add_point(-524288, -524288, 0);
    add_point(524287, 524287, 1);
    add_point(524287, -524288, 0);
    add_point(-524288, 524287, 0);
    add_point(-524288, -524288, 1);
    drain();

    write_all(12'd4095, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_NONE_LO, 16'h0123);
    write_reg(REG_NONE_HI, 16'hFFFF);
    add_point(524287, 524287, 0);
    add_point(-524288, 524287, 0);
    add_point(-524288, -524288, 0);
    add_point(-524288, -524288, 0);
    add_point(3, 1, 1);
    add_point(-1, -1, 1);
    drain();

    write_all(12'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFA);
    add_point(100, 200, 0);
    add_point(-100, 250, 0);
    add_point(-50, 50, 1);
    drain();

    // random phases with random settings, one without any idling
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_all(HW'($urandom_range(4095)), TW'($urandom_range(65535)),
                TW'($urandom_range(65535)), TW'($urandom_range(65535)),
                TW'($urandom_range(65535)), TW'($urandom_range(65535)));
      quiet = (ph == 2);
      while (sent < (ph + 1) * 33) begin
        int n = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
        add_polyline(n);
        sent += n;
      end
      drain();
      quiet = 0;
    end

    if (expected_beats.size() != 0) report("expected beats never arrived");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[polyline_extrude_to_triangles.f]
rtl/pet_pkg.sv
rtl/pet_if.sv
rtl/pet_front.sv
rtl/pet_queue.sv
rtl/pet_back.sv
rtl/polyline_extrude_to_triangles.sv
verif/tb.sv
